@@ hdl/bmhq_pkg.sv @@
// ----------------------------------------------------------------------------
// bmhq_pkg
// shared constants and codes for the binary max-heap priority queue
// ----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

    localparam int CAPACITY_DEFAULT       = 64;
    localparam int PRIORITY_WIDTH_DEFAULT = 16;
    localparam int TAG_WIDTH_DEFAULT      = 16;

    localparam int STATUS_WIDTH = 2;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_REMOVED  = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } func_t;

endpackage

`default_nettype wire

@@ hdl/bmhq_if.sv @@
// ----------------------------------------------------------------------------
// bmhq_req_if / bmhq_rsp_if
// valid/ready channels for heap requests and results
// ----------------------------------------------------------------------------
`default_nettype none

interface bmhq_req_if #(
    parameter int PRIORITY_WIDTH = bmhq_pkg::PRIORITY_WIDTH_DEFAULT,
    parameter int TAG_WIDTH      = bmhq_pkg::TAG_WIDTH_DEFAULT
) ();
    logic                             valid;
    logic                             ready;
    bmhq_pkg::func_t                  func;
    logic signed [PRIORITY_WIDTH-1:0] priority_req;
    logic        [TAG_WIDTH-1:0]      tag;

    modport source (output valid, func, priority_req, tag, input ready);
    modport sink   (input valid, func, priority_req, tag, output ready);
endinterface

interface bmhq_rsp_if #(
    parameter int CAPACITY       = bmhq_pkg::CAPACITY_DEFAULT,
    parameter int PRIORITY_WIDTH = bmhq_pkg::PRIORITY_WIDTH_DEFAULT,
    parameter int TAG_WIDTH      = bmhq_pkg::TAG_WIDTH_DEFAULT
) ();
    localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

    logic                             valid;
    logic                             ready;
    bmhq_pkg::status_t                status;
    logic signed [PRIORITY_WIDTH-1:0] out_priority;
    logic        [TAG_WIDTH-1:0]      out_tag;
    logic        [COUNT_WIDTH-1:0]    count;

    modport source (output valid, status, out_priority, out_tag, count, input ready);
    modport sink   (input valid, status, out_priority, out_tag, count, output ready);
endinterface

`default_nettype wire

@@ hdl/binary_max_heap_queue.sv @@
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// fixed-capacity max-heap priority queue of (signed priority, tag) entries
// ----------------------------------------------------------------------------
// One request at a time: an insert appends the entry and sifts it up while it
// is strictly greater than its parent; a remove returns the root, moves the
// last entry to the root and sifts it down, taking the right child only when
// strictly greater than the best so far. Entries live in a single-port-read
// memory with registered read data, so each heap level costs one memory read
// per comparison. An insert reads the parent, then compares and writes at each
// level; a remove reads the root and then the last entry, and at each level
// reads the left child, then the right child, then compares and writes. A
// full insert or an empty remove goes straight to the result state. The
// request channel is ready only between operations; a finished result is held
// in the output register until taken, and a result still waiting there stalls
// the next operation in its result state. Heap memory needs no clearing after
// reset since only entries below the count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_max_heap_queue #(
    parameter int CAPACITY       = bmhq_pkg::CAPACITY_DEFAULT,
    parameter int PRIORITY_WIDTH = bmhq_pkg::PRIORITY_WIDTH_DEFAULT,
    parameter int TAG_WIDTH      = bmhq_pkg::TAG_WIDTH_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bmhq_req_if.sink   req,
    bmhq_rsp_if.source rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;
    localparam int EW = PRIORITY_WIDTH + TAG_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_RM_TOP,
        S_RM_LAST,
        S_RM_X,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [CW-1:0]        count_reg;
    logic [AW-1:0]        cur_reg;
    logic [EW-1:0]        x_reg;
    logic [EW-1:0]        top_reg;
    logic [EW-1:0]        l_reg;
    logic                 r_ok_reg;
    bmhq_pkg::status_t    res_status_reg;

    logic                 out_valid_reg;
    bmhq_pkg::status_t    out_status_reg;
    logic [PRIORITY_WIDTH-1:0] out_prio_reg;
    logic [TAG_WIDTH-1:0] out_tag_reg;
    logic [CW-1:0]        out_count_reg;

    logic [EW-1:0]        mem [CAPACITY];
    logic [EW-1:0]        rdata_reg;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [EW-1:0]        wr_data;

    logic [IW-1:0]        left_idx;
    logic [IW-1:0]        right_idx;
    logic [AW-1:0]        parent_idx;
    logic                 left_in;
    logic                 right_in;
    logic signed [PRIORITY_WIDTH-1:0] x_prio;
    logic signed [PRIORITY_WIDTH-1:0] rd_prio;
    logic signed [PRIORITY_WIDTH-1:0] l_prio;
    logic signed [PRIORITY_WIDTH-1:0] best_prio;
    logic                 take_l;
    logic                 take_r;
    logic                 up_swap;
    logic                 accept;
    logic                 out_free;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;

    assign left_idx   = {1'b0, cur_reg, 1'b1};
    assign right_idx  = {1'b0, cur_reg, 1'b0} + IW'(2);
    assign parent_idx = AW'((cur_reg - AW'(1)) >> 1);
    assign left_in    = left_idx < IW'(count_reg);
    assign right_in   = right_idx < IW'(count_reg);

    assign x_prio    = $signed(x_reg[EW-1 -: PRIORITY_WIDTH]);
    assign rd_prio   = $signed(rdata_reg[EW-1 -: PRIORITY_WIDTH]);
    assign l_prio    = $signed(l_reg[EW-1 -: PRIORITY_WIDTH]);
    assign up_swap   = x_prio > rd_prio;
    assign take_l    = l_prio > x_prio;
    assign best_prio = take_l ? l_prio : x_prio;
    assign take_r    = r_ok_reg && (rd_prio > best_prio);

    // memory address and write control
    always_comb
    begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = cur_reg;
        wr_data = x_reg;
        unique case (state_reg)
            S_UP_RD:
            begin
                rd_addr = parent_idx;
                if (cur_reg == '0)
                begin
                    wr_en = 1'b1;
                end
            end
            S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (up_swap)
                begin
                    wr_data = rdata_reg;
                end
            end
            S_RM_TOP:
            begin
                rd_addr = '0;
            end
            S_RM_LAST:
            begin
                rd_addr = AW'(count_reg - CW'(1));
            end
            S_DN_L:
            begin
                rd_addr = left_idx[AW-1:0];
                if (!left_in)
                begin
                    wr_en = 1'b1;
                end
            end
            S_DN_R:
            begin
                rd_addr = right_idx[AW-1:0];
            end
            S_DN_CMP:
            begin
                wr_en = 1'b1;
                priority if (take_r)
                begin
                    wr_data = rdata_reg;
                end
                else if (take_l)
                begin
                    wr_data = l_reg;
                end
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            cur_reg        <= '0;
            x_reg          <= '0;
            top_reg        <= '0;
            l_reg          <= '0;
            res_status_reg <= bmhq_pkg::ST_INSERTED;
            r_ok_reg       <= 1'b0;
            out_status_reg <= bmhq_pkg::ST_INSERTED;
            out_prio_reg   <= '0;
            out_tag_reg    <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (req.func == bmhq_pkg::FUNC_INSERT)
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                res_status_reg <= bmhq_pkg::ST_FULL;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                res_status_reg <= bmhq_pkg::ST_INSERTED;
                                x_reg          <= {req.priority_req, req.tag};
                                cur_reg        <= AW'(count_reg);
                                count_reg      <= count_reg + CW'(1);
                                state_reg      <= S_UP_RD;
                            end
                        end
                        else
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_reg <= bmhq_pkg::ST_EMPTY;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                res_status_reg <= bmhq_pkg::ST_REMOVED;
                                state_reg      <= S_RM_TOP;
                            end
                        end
                    end
                end
                S_UP_RD:
                begin
                    state_reg <= (cur_reg == '0) ? S_DONE : S_UP_CMP;
                end
                S_UP_CMP:
                begin
                    if (up_swap)
                    begin
                        cur_reg   <= parent_idx;
                        state_reg <= S_UP_RD;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_RM_TOP:
                begin
                    state_reg <= S_RM_LAST;
                end
                S_RM_LAST:
                begin
                    top_reg   <= rdata_reg;
                    count_reg <= count_reg - CW'(1);
                    state_reg <= S_RM_X;
                end
                S_RM_X:
                begin
                    x_reg     <= rdata_reg;
                    cur_reg   <= '0;
                    state_reg <= S_DN_L;
                end
                S_DN_L:
                begin
                    state_reg <= left_in ? S_DN_R : S_DONE;
                end
                S_DN_R:
                begin
                    l_reg     <= rdata_reg;
                    r_ok_reg  <= right_in;
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP:
                begin
                    priority if (take_r)
                    begin
                        cur_reg   <= right_idx[AW-1:0];
                        state_reg <= S_DN_L;
                    end
                    else if (take_l)
                    begin
                        cur_reg   <= left_idx[AW-1:0];
                        state_reg <= S_DN_L;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_count_reg  <= count_reg;
                        if (res_status_reg == bmhq_pkg::ST_REMOVED)
                        begin
                            out_prio_reg <= top_reg[EW-1 -: PRIORITY_WIDTH];
                            out_tag_reg  <= top_reg[TAG_WIDTH-1:0];
                        end
                        else
                        begin
                            out_prio_reg <= '0;
                            out_tag_reg  <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.out_priority = $signed(out_prio_reg);
    assign rsp.out_tag      = out_tag_reg;
    assign rsp.count        = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("request taken while an operation is in progress");

    a_sift_up_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP_RD) |-> (CW'(cur_reg) < count_reg))
        else $error("sift-up position beyond the heap");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == bmhq_pkg::ST_EMPTY) |-> (out_count_reg == '0))
        else $error("empty status with entries held");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == bmhq_pkg::ST_FULL)
            |-> (out_count_reg == CW'(CAPACITY)))
        else $error("full status below capacity");

endmodule

`default_nettype wire
